/* hw/rtl/spi_byte_stuffed_link_codec_defines.svh */
// ----------------------------------------------------------------------------
// Link codec assertion macros
// Shared concurrent assertion forms for the byte-stuffed link codec.
// ----------------------------------------------------------------------------
`ifndef SPI_BYTE_STUFFED_LINK_CODEC_DEFINES_SVH
`define SPI_BYTE_STUFFED_LINK_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SBSLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBSLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sbslc_pkg.sv */
// ----------------------------------------------------------------------------
// Link codec package
// Types and fixed constants shared by the byte-stuffed link codec modules.
// ----------------------------------------------------------------------------
package sbslc_pkg;

   localparam int ByteW  = 8;
   localparam int FillW  = 10;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      ACT_RECEIVE = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_POP     = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   // What a received byte means when no escape is pending.
   typedef enum logic [2:0] {
      RX_DATA,
      RX_DROP,
      RX_ESCAPE,
      RX_RESUME,
      RX_STOP
   } rx_class_type;

   typedef enum logic [2:0] {
      CSR_ESCAPE_CODE   = 3'd0,
      CSR_ESCAPE_MASK   = 3'd1,
      CSR_IDLE_CODE     = 3'd2,
      CSR_RESUME_CODE   = 3'd3,
      CSR_STOP_CODE     = 3'd4,
      CSR_READY_CODE    = 3'd5,
      CSR_INACT_HI_CODE = 3'd6,
      CSR_INACT_LO_CODE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_SEND2,
      BK_POP
   } back_state_type;

   typedef struct packed {
      logic [ByteW-1:0] escape_code;
      logic [ByteW-1:0] escape_mask;
      logic [ByteW-1:0] idle_code;
      logic [ByteW-1:0] resume_code;
      logic [ByteW-1:0] stop_code;
      logic [ByteW-1:0] ready_code;
      logic [ByteW-1:0] inact_hi_code;
      logic [ByteW-1:0] inact_lo_code;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      escape_code:   8'd251,
      escape_mask:   8'd32,
      idle_code:     8'd245,
      resume_code:   8'd250,
      stop_code:     8'd253,
      ready_code:    8'd243,
      inact_hi_code: 8'd255,
      inact_lo_code: 8'd0
   };

   // One decoded item as it travels from front to back.
   typedef struct packed {
      action_type       action;
      logic [ByteW-1:0] data;
      rx_class_type     rx_class;
      logic             special;
   } op_type;

   typedef struct packed {
      logic             last;
      logic             peer_stopped;
      logic [FillW-1:0] fill_count;
      status_type       status;
      logic [ByteW-1:0] read_byte;
      logic             read_valid;
      logic [ByteW-1:0] link_out_byte;
      logic             link_out_valid;
   } rsp_type;

endpackage

/* hw/rtl/sbslc_front.sv */
// ----------------------------------------------------------------------------
// Link codec front end
// Accepts request beats, matches the byte against the link codes, and
// hands a decoded op to the queue.
// ----------------------------------------------------------------------------
module sbslc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  sbslc_pkg::cfg_type             cfg,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sbslc_pkg::ByteW-1:0]    req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic                           push_valid,
   input  logic                           push_ready,
   output sbslc_pkg::op_type              push_op
);

   logic                  valid_ff, valid_in;
   sbslc_pkg::op_type     op_ff, op_in;
   sbslc_pkg::rx_class_type rx_class;
   logic                  special;
   logic                  take;

   // Receive priority: idle, escape, resume, stop, then the other drop codes.
   always_comb begin
      priority if (req_tdata == cfg.idle_code) begin
         rx_class = sbslc_pkg::RX_DROP;
      end else if (req_tdata == cfg.escape_code) begin
         rx_class = sbslc_pkg::RX_ESCAPE;
      end else if (req_tdata == cfg.resume_code) begin
         rx_class = sbslc_pkg::RX_RESUME;
      end else if (req_tdata == cfg.stop_code) begin
         rx_class = sbslc_pkg::RX_STOP;
      end else if (req_tdata == cfg.ready_code || req_tdata == cfg.inact_hi_code ||
                   req_tdata == cfg.inact_lo_code) begin
         rx_class = sbslc_pkg::RX_DROP;
      end else begin
         rx_class = sbslc_pkg::RX_DATA;
      end
      special = (rx_class != sbslc_pkg::RX_DATA);
   end

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_op    = op_ff;

   always_comb begin
      op_in          = op_ff;
      valid_in       = valid_ff && !push_ready;
      if (take) begin
         op_in.action   = sbslc_pkg::action_type'(req_tuser);
         op_in.data     = req_tdata;
         op_in.rx_class = rx_class;
         op_in.special  = special;
         valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

/* hw/rtl/sbslc_queue.sv */
// ----------------------------------------------------------------------------
// Link codec op queue
// Short ring of decoded ops between front end and back end.
// ----------------------------------------------------------------------------
module sbslc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sbslc_pkg::op_type push_op,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sbslc_pkg::op_type pop_op
);

   localparam int PtrW = $clog2(sbslc_pkg::QueueDepth);
   localparam int CntW = $clog2(sbslc_pkg::QueueDepth + 1);

   sbslc_pkg::op_type entry_ff [sbslc_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CntW'(sbslc_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(sbslc_pkg::QueueDepth - 1)) ? '0
                                                                      : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(sbslc_pkg::QueueDepth - 1)) ? '0
                                                                      : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

/* hw/rtl/sbslc_back.sv */
// ----------------------------------------------------------------------------
// Link codec back end
// Executes decoded ops: unescape and store, stuff sends, pop and clear the
// receive FIFO, and hold each result beat in an output register.
// ----------------------------------------------------------------------------
`include "spi_byte_stuffed_link_codec_defines.svh"

module sbslc_back #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  sbslc_pkg::cfg_type cfg,
   input  logic               op_valid,
   output logic               op_ready,
   input  sbslc_pkg::op_type  op,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sbslc_pkg::rsp_type rsp
);

   localparam int PtrW = $clog2(FIFO_DEPTH);

   sbslc_pkg::back_state_type state_ff, state_in;
   logic [PtrW-1:0]   wp_ff, wp_in, rp_ff, rp_in, cnt_ff, cnt_in;
   logic              esc_ff, esc_in, stop_ff, stop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sbslc_pkg::rsp_type rsp_ff, rsp_in;
   logic [sbslc_pkg::ByteW-1:0] hold_ff, hold_in;
   logic [sbslc_pkg::ByteW-1:0] rd_data_ff;
   logic [sbslc_pkg::ByteW-1:0] mem [FIFO_DEPTH];
   logic              mem_we, mem_re;
   logic [sbslc_pkg::ByteW-1:0] mem_wdata;
   logic              out_free, fifo_full;
   logic              load;
   logic [sbslc_pkg::ByteW-1:0] push_byte;
   logic              want_push;
   sbslc_pkg::status_type status;
   logic              last, lv, rv;
   logic [sbslc_pkg::ByteW-1:0] lb, rb;
   logic [PtrW:0]     ptr_diff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fifo_full = (cnt_ff == PtrW'(FIFO_DEPTH - 1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      cnt_in    = cnt_ff;
      esc_in    = esc_ff;
      stop_in   = stop_ff;
      hold_in   = hold_ff;
      op_ready  = 1'b0;
      load      = 1'b0;
      mem_re    = 1'b0;
      want_push = 1'b0;
      push_byte = op.data;
      status    = sbslc_pkg::ST_OK;
      last      = 1'b1;
      lv        = 1'b0;
      lb        = '0;
      rv        = 1'b0;
      rb        = '0;

      unique case (state_ff)
         sbslc_pkg::BK_RUN: begin
            if (op_valid && out_free) begin
               op_ready = 1'b1;
               unique case (op.action)
                  sbslc_pkg::ACT_RECEIVE: begin
                     load = 1'b1;
                     if (esc_ff) begin
                        want_push = 1'b1;
                        push_byte = op.data ^ cfg.escape_mask;
                        esc_in    = 1'b0;
                     end else begin
                        unique case (op.rx_class)
                           sbslc_pkg::RX_DATA:   want_push = 1'b1;
                           sbslc_pkg::RX_ESCAPE: esc_in    = 1'b1;
                           sbslc_pkg::RX_RESUME: stop_in   = 1'b0;
                           sbslc_pkg::RX_STOP:   stop_in   = 1'b1;
                           sbslc_pkg::RX_DROP:   ;
                           default:              ;
                        endcase
                     end
                     if (want_push) begin
                        if (fifo_full) begin
                           status = sbslc_pkg::ST_FULL;
                        end else begin
                           wp_in  = (wp_ff == PtrW'(FIFO_DEPTH - 1)) ? '0 : wp_ff + PtrW'(1);
                           cnt_in = cnt_ff + PtrW'(1);
                        end
                     end
                  end
                  sbslc_pkg::ACT_SEND: begin
                     load = 1'b1;
                     if (stop_ff) begin
                        status = sbslc_pkg::ST_REFUSED;
                     end else if (op.special) begin
                        lv       = 1'b1;
                        lb       = cfg.escape_code;
                        last     = 1'b0;
                        hold_in  = op.data ^ cfg.escape_mask;
                        state_in = sbslc_pkg::BK_SEND2;
                     end else begin
                        lv = 1'b1;
                        lb = op.data;
                     end
                  end
                  sbslc_pkg::ACT_POP: begin
                     if (cnt_ff == '0) begin
                        load   = 1'b1;
                        status = sbslc_pkg::ST_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        rp_in    = (rp_ff == PtrW'(FIFO_DEPTH - 1)) ? '0 : rp_ff + PtrW'(1);
                        cnt_in   = cnt_ff - PtrW'(1);
                        state_in = sbslc_pkg::BK_POP;
                     end
                  end
                  sbslc_pkg::ACT_CLEAR: begin
                     load   = 1'b1;
                     wp_in  = '0;
                     rp_in  = '0;
                     cnt_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         sbslc_pkg::BK_SEND2: begin
            if (out_free) begin
               load     = 1'b1;
               lv       = 1'b1;
               lb       = hold_ff;
               state_in = sbslc_pkg::BK_RUN;
            end
         end
         sbslc_pkg::BK_POP: begin
            if (out_free) begin
               load     = 1'b1;
               rv       = 1'b1;
               rb       = rd_data_ff;
               state_in = sbslc_pkg::BK_RUN;
            end
         end
         default: state_in = sbslc_pkg::BK_RUN;
      endcase

      mem_we    = want_push && !fifo_full;
      mem_wdata = push_byte;

      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.link_out_valid = lv;
         rsp_in.link_out_byte  = lb;
         rsp_in.read_valid     = rv;
         rsp_in.read_byte      = rb;
         rsp_in.status         = status;
         rsp_in.fill_count     = sbslc_pkg::FillW'(cnt_in);
         rsp_in.peer_stopped   = stop_in;
         rsp_in.last           = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbslc_pkg::BK_RUN;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         esc_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         esc_ff       <= esc_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   // Receive store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   // Pointer distance, for checking the fill counter.
   always_comb begin
      if (wp_ff >= rp_ff) begin
         ptr_diff = {1'b0, wp_ff} - {1'b0, rp_ff};
      end else begin
         ptr_diff = {1'b0, wp_ff} + (PtrW+1)'(FIFO_DEPTH) - {1'b0, rp_ff};
      end
   end

   `SBSLC_ASSERT_SAME(a_cnt_matches_ptrs, clock, reset, 1'b1,
      ptr_diff == {1'b0, cnt_ff}, "fill counter disagrees with pointers")

   `SBSLC_ASSERT_SAME(a_send2_holds_first, clock, reset, state_ff == sbslc_pkg::BK_SEND2,
      rsp_valid_ff && !rsp_ff.last && rsp_ff.link_out_valid, "escape beat not held")

   `SBSLC_ASSERT_NEXT(a_pop_reads, clock, reset,
      state_ff == sbslc_pkg::BK_RUN && op_valid && out_free &&
      op.action == sbslc_pkg::ACT_POP && cnt_ff != '0,
      state_ff == sbslc_pkg::BK_POP, "pop of a filled FIFO did not read")

endmodule

/* hw/rtl/spi_byte_stuffed_link_codec.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed SPI link codec
// Link layer with escape stuffing, XON/XOFF flow control and receive FIFO.
// ----------------------------------------------------------------------------
// Usage
//  req_ channel: one beat per link event. tuser is the action (receive a
//  link byte, send a data byte, pop the FIFO, clear the FIFO), tdata the byte.
//  rsp_ channel: result beats, tlast on the final beat of each request. A
//  stuffed send gives two beats (escape code, then byte XOR mask).
//  csr_ channel: register writes, always ready; write only while idle.
// Flow
//  A request reaches its first result beat via the front register, op queue
//  and result register; a pop also passes the registered store read.
//  The back end retires one request per cycle while the result register is
//  free; a stuffed send or a filled-FIFO pop holds it in BK_SEND2 or BK_POP
//  for the second beat or store read. The front keeps filling the 2-entry queue.
// Reset
//  Synchronous; pointers, fill count, escape and stop flags clear, the
//  registers take their defaults. No store clearing pass is run.
// Stall
//  While rsp_tready is low the result register holds, the back end waits and
//  the queue fills; req_tready drops once front and queue are both full.
// ----------------------------------------------------------------------------
module spi_byte_stuffed_link_codec #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] link_out_valid, [8:1] link_out_byte,
                                    // [9] read_valid, [17:10] read_byte,
                                    // [19:18] status, [29:20] fill_count,
                                    // [30] peer_stopped, [31] zero
   output logic        rsp_tlast,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   sbslc_pkg::cfg_type cfg_ff, cfg_in;
   logic               fq_valid, fq_ready;
   sbslc_pkg::op_type  fq_op;
   logic               qb_valid, qb_ready;
   sbslc_pkg::op_type  qb_op;
   sbslc_pkg::rsp_type rsp;

   // Register file: writes complete in the beat they are offered.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (sbslc_pkg::csr_index_type'(csr_index))
            sbslc_pkg::CSR_ESCAPE_CODE:   cfg_in.escape_code   = csr_wdata;
            sbslc_pkg::CSR_ESCAPE_MASK:   cfg_in.escape_mask   = csr_wdata;
            sbslc_pkg::CSR_IDLE_CODE:     cfg_in.idle_code     = csr_wdata;
            sbslc_pkg::CSR_RESUME_CODE:   cfg_in.resume_code   = csr_wdata;
            sbslc_pkg::CSR_STOP_CODE:     cfg_in.stop_code     = csr_wdata;
            sbslc_pkg::CSR_READY_CODE:    cfg_in.ready_code    = csr_wdata;
            sbslc_pkg::CSR_INACT_HI_CODE: cfg_in.inact_hi_code = csr_wdata;
            sbslc_pkg::CSR_INACT_LO_CODE: cfg_in.inact_lo_code = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sbslc_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify against the link codes.
   sbslc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_op    (fq_op)
   );

   // Decouples the front from back-end stalls.
   sbslc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_op    (fq_op),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_op     (qb_op)
   );

   // Back: link state, receive store and result register.
   sbslc_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (qb_valid),
      .op_ready  (qb_ready),
      .op        (qb_op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.peer_stopped, rsp.fill_count, rsp.status, rsp.read_byte,
                       rsp.read_valid, rsp.link_out_byte, rsp.link_out_valid};
   assign rsp_tlast = rsp.last;

endmodule

/* tb/link_codec_check_pkg.sv */
// ----------------------------------------------------------------------------
// Link codec scoreboard
// Behavioural model of the byte-stuffed link codec plus the queue of result
// beats it predicts; each result beat from the block is checked against it.
// ----------------------------------------------------------------------------
package link_codec_check_pkg;

   import sbslc_pkg::*;

   typedef struct {
      bit         tx_valid;
      bit [7:0]   tx_byte;
      bit         rd_valid;
      bit [7:0]   rd_byte;
      status_type status;
      bit [9:0]   fill;
      bit         halted;
      bit         tail;
   } link_beat_t;

   class link_codec_scoreboard;
      cfg_type    codes;
      bit [7:0]   rx_fifo [1024];
      bit [9:0]   wr_ptr;
      bit [9:0]   rd_ptr;
      bit         esc_armed;
      bit         peer_halted;
      link_beat_t due_beats [$];
      int         errors;

      function new();
         codes       = CfgReset;
         wr_ptr      = '0;
         rd_ptr      = '0;
         esc_armed   = 1'b0;
         peer_halted = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [7:0] v);
         case (idx)
            CSR_ESCAPE_CODE:   codes.escape_code   = v;
            CSR_ESCAPE_MASK:   codes.escape_mask   = v;
            CSR_IDLE_CODE:     codes.idle_code     = v;
            CSR_RESUME_CODE:   codes.resume_code   = v;
            CSR_STOP_CODE:     codes.stop_code     = v;
            CSR_READY_CODE:    codes.ready_code    = v;
            CSR_INACT_HI_CODE: codes.inact_hi_code = v;
            CSR_INACT_LO_CODE: codes.inact_lo_code = v;
            default: ;
         endcase
      endfunction

      function bit [9:0] fill_level();
         return wr_ptr - rd_ptr;
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      // one slot always stays empty
      function status_type push_rx(bit [7:0] b);
         if (wr_ptr + 10'd1 == rd_ptr) return ST_FULL;
         rx_fifo[wr_ptr] = b;
         wr_ptr++;
         return ST_OK;
      endfunction

      function bit is_code(bit [7:0] b);
         return b == codes.escape_code || b == codes.resume_code ||
                b == codes.stop_code || b == codes.idle_code ||
                b == codes.ready_code || b == codes.inact_lo_code ||
                b == codes.inact_hi_code;
      endfunction

      function void queue_beat(bit txv, bit [7:0] txb, bit rdv, bit [7:0] rdb,
                               status_type st, bit tail);
         link_beat_t e;
         e.tx_valid = txv;
         e.tx_byte  = txb;
         e.rd_valid = rdv;
         e.rd_byte  = rdb;
         e.status   = st;
         e.fill     = fill_level();
         e.halted   = peer_halted;
         e.tail     = tail;
         due_beats.push_back(e);
      endfunction

      // Note an accepted request beat and queue the result beats it causes.
      function void accept_request(action_type act, bit [7:0] b);
         status_type st;
         bit [7:0]   v;
         st = ST_OK;
         case (act)
            ACT_RECEIVE: begin
               // match order: idle, escape, resume, stop, then the dropped codes
               if (esc_armed) begin
                  st = push_rx(b ^ codes.escape_mask);
                  esc_armed = 1'b0;
               end else if (b == codes.idle_code) begin
               end else if (b == codes.escape_code) begin
                  esc_armed = 1'b1;
               end else if (b == codes.resume_code) begin
                  peer_halted = 1'b0;
               end else if (b == codes.stop_code) begin
                  peer_halted = 1'b1;
               end else if (b == codes.ready_code || b == codes.inact_hi_code ||
                            b == codes.inact_lo_code) begin
               end else begin
                  st = push_rx(b);
               end
               queue_beat(1'b0, 8'h00, 1'b0, 8'h00, st, 1'b1);
            end
            ACT_SEND: begin
               if (peer_halted) begin
                  queue_beat(1'b0, 8'h00, 1'b0, 8'h00, ST_REFUSED, 1'b1);
               end else if (is_code(b)) begin
                  queue_beat(1'b1, codes.escape_code, 1'b0, 8'h00, ST_OK, 1'b0);
                  queue_beat(1'b1, b ^ codes.escape_mask, 1'b0, 8'h00, ST_OK, 1'b1);
               end else begin
                  queue_beat(1'b1, b, 1'b0, 8'h00, ST_OK, 1'b1);
               end
            end
            ACT_POP: begin
               if (rd_ptr == wr_ptr) begin
                  queue_beat(1'b0, 8'h00, 1'b0, 8'h00, ST_EMPTY, 1'b1);
               end else begin
                  v = rx_fifo[rd_ptr];
                  rd_ptr++;
                  queue_beat(1'b0, 8'h00, 1'b1, v, ST_OK, 1'b1);
               end
            end
            default: begin
               // clear keeps the escape and stop flags
               wr_ptr = '0;
               rd_ptr = '0;
               foreach (rx_fifo[i]) rx_fifo[i] = 8'h00;
               queue_beat(1'b0, 8'h00, 1'b0, 8'h00, ST_OK, 1'b1);
            end
         endcase
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task compare(string name, logic [9:0] got, logic [9:0] want);
         if (got !== want)
            report($sformatf("%s got %0h, want %0h", name, got, want));
      endtask

      task check_beat(logic [31:0] d, logic tlast);
         link_beat_t e;
         if (due_beats.size() == 0) begin
            report($sformatf("result beat with nothing outstanding, tdata %h", d));
            return;
         end
         e = due_beats.pop_front();
         compare("link_out_valid", d[0], e.tx_valid);
         compare("link_out_byte", d[8:1], e.tx_byte);
         compare("read_valid", d[9], e.rd_valid);
         compare("read_byte", d[17:10], e.rd_byte);
         compare("status", d[19:18], e.status);
         compare("fill_count", d[29:20], e.fill);
         compare("peer_stopped", d[30], e.halted);
         compare("tdata pad bit", d[31], 1'b0);
         compare("tlast", tlast, e.tail);
      endtask
   endclass

endpackage

/* tb/spi_byte_stuffed_link_codec_tb.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed link codec testbench
// Drives receive, send, pop and clear beats through several code settings,
// fills the receive FIFO to overflow, and checks every result beat against a
// scoreboard model under random back-pressure and idle gaps.
// ----------------------------------------------------------------------------
module spi_byte_stuffed_link_codec_tb;

   import sbslc_pkg::*;
   import link_codec_check_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] byte_in
   logic [1:0]  req_tuser;     // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [0] link_out_valid, [8:1] link_out_byte,
                               // [9] read_valid, [17:10] read_byte,
                               // [19:18] status, [29:20] fill_count,
                               // [30] peer_stopped, [31] zero
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;

   link_codec_scoreboard sb;

   // idle percentages per cycle, stepped through by request count
   int sender_idle_pct   = 29;
   int receiver_idle_pct = 88;
   int items_sent        = 0;
   // long receiver hold-offs: requested by stimulus, served by the sink
   int hold_requests     = 0;
   int holds_served      = 0;

   // Directed opening under reset codes: empty pop, stuffed and plain sends,
   // every dropped code, escaped receive (including an escaped escape code),
   // XOFF refusing a send then XON, pops, and a clear with an escape armed.
   localparam action_type DirActs [25] = '{
      ACT_POP, ACT_SEND, ACT_SEND, ACT_SEND, ACT_SEND,
      ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE,
      ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE, ACT_RECEIVE,
      ACT_SEND, ACT_RECEIVE, ACT_SEND, ACT_POP, ACT_POP,
      ACT_RECEIVE, ACT_CLEAR, ACT_RECEIVE, ACT_POP, ACT_POP
   };
   localparam logic [7:0] DirData [25] = '{
      8'h00, 8'h00, 8'hFF, 8'h41, 8'hFB,
      8'h41, 8'h00, 8'hFF, 8'hF5, 8'hF3,
      8'hFB, 8'hDB, 8'hFB, 8'hFB, 8'hFD,
      8'h55, 8'hFA, 8'h80, 8'h00, 8'hFF,
      8'hFB, 8'hA5, 8'hD0, 8'h00, 8'h00
   };

   spi_byte_stuffed_link_codec dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Offer one request beat; valid is only dropped for an idle gap, so
   // back-to-back beats keep it high without a glitch.
   task automatic send_item(action_type act, logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.accept_request(act, data);
      items_sent++;
      if (items_sent < 650) begin
         sender_idle_pct   = 29;
         receiver_idle_pct = 88;
      end else if (items_sent < 1300) begin
         sender_idle_pct   = 88;
         receiver_idle_pct = 29;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write all eight code registers, block idle.
   task automatic load_codes(cfg_type c);
      csr_index_type idx;
      logic [7:0]    v;
      drain();
      idx = idx.first();
      forever begin
         case (idx)
            CSR_ESCAPE_CODE:   v = c.escape_code;
            CSR_ESCAPE_MASK:   v = c.escape_mask;
            CSR_IDLE_CODE:     v = c.idle_code;
            CSR_RESUME_CODE:   v = c.resume_code;
            CSR_STOP_CODE:     v = c.stop_code;
            CSR_READY_CODE:    v = c.ready_code;
            CSR_INACT_HI_CODE: v = c.inact_hi_code;
            default:           v = c.inact_lo_code;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, v);
         if (idx == idx.last()) break;
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   // a live code about a third of the time, otherwise any byte
   function automatic logic [7:0] pick_link_byte();
      case ($urandom_range(20))
         0:       return sb.codes.escape_code;
         1:       return sb.codes.idle_code;
         2:       return sb.codes.resume_code;
         3:       return sb.codes.stop_code;
         4:       return sb.codes.ready_code;
         5:       return sb.codes.inact_hi_code;
         6:       return sb.codes.inact_lo_code;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed traffic: data, escape pairs, XON/XOFF, sends, pops;
   // a sprinkling of clears and raw noise.
   task automatic random_traffic(int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            send_item(ACT_RECEIVE, pick_link_byte());
         end else if (pick < 52) begin
            send_item(ACT_RECEIVE, sb.codes.escape_code);
            send_item(ACT_RECEIVE, pick_link_byte());
         end else if (pick < 58) begin
            // favour XON so sends are not refused for too long
            send_item(ACT_RECEIVE, ($urandom_range(2) == 0) ? sb.codes.stop_code
                                                            : sb.codes.resume_code);
         end else if (pick < 77) begin
            send_item(ACT_SEND, pick_link_byte());
         end else if (pick < 96) begin
            send_item(ACT_POP, 8'($urandom));
         end else begin
            send_item(ACT_CLEAR, 8'($urandom));
         end
      end
   endtask

   // Result sink: checks every accepted beat, random back-pressure, and the
   // long hold-off that lets the op queue fill and stall the request side.
   initial begin : result_sink
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_beat(rsp_tdata, rsp_tlast);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin : stimulus
      cfg_type phase_codes;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = ACT_RECEIVE;
      csr_valid  = 1'b0;
      csr_index  = CSR_ESCAPE_CODE;
      csr_wdata  = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset codes, directed beats
      for (int i = 0; i < 25; i++) send_item(DirActs[i], DirData[i]);

      // random codes; long receiver hold-off early on
      phase_codes = {$urandom, $urandom};
      load_codes(phase_codes);
      hold_requests++;
      random_traffic(350);

      // extreme codes, with collisions: ready on escape, inactive high on idle
      phase_codes = '{escape_code: 8'h00, escape_mask: 8'hFF, idle_code: 8'hFF,
                      resume_code: 8'h01, stop_code: 8'hFE, ready_code: 8'h00,
                      inact_hi_code: 8'hFF, inact_lo_code: 8'h80};
      load_codes(phase_codes);
      // fill the FIFO to its 1023-byte limit, second hold-off on the way
      hold_requests++;
      while (sb.fill_level() != 10'd1023) begin
         if ($urandom_range(9) == 0) begin
            send_item(ACT_RECEIVE, sb.codes.escape_code);
            send_item(ACT_RECEIVE, 8'($urandom));
         end else begin
            send_item(ACT_RECEIVE, 8'($urandom));
         end
      end
      // overflow: plain and escaped bytes dropped, then pop and refill
      send_item(ACT_RECEIVE, 8'h5A);
      send_item(ACT_RECEIVE, 8'hA5);
      send_item(ACT_RECEIVE, sb.codes.escape_code);
      send_item(ACT_RECEIVE, 8'h3C);
      send_item(ACT_RECEIVE, sb.codes.resume_code);
      send_item(ACT_SEND, 8'h00);
      send_item(ACT_SEND, 8'h7F);
      send_item(ACT_POP, 8'h00);
      send_item(ACT_RECEIVE, 8'h66);
      send_item(ACT_RECEIVE, 8'h99);
      random_traffic(150);

      // colliding codes, zero mask: idle hides escape, resume hides stop
      phase_codes = '{escape_code: 8'h11, escape_mask: 8'h00, idle_code: 8'h11,
                      resume_code: 8'h13, stop_code: 8'h13, ready_code: 8'h7E,
                      inact_hi_code: 8'h7E, inact_lo_code: 8'h7D};
      load_codes(phase_codes);
      random_traffic(200);

      // other extremes
      phase_codes = '{escape_code: 8'hFF, escape_mask: 8'h80, idle_code: 8'h00,
                      resume_code: 8'h11, stop_code: 8'h13, ready_code: 8'h80,
                      inact_hi_code: 8'h01, inact_lo_code: 8'hFE};
      load_codes(phase_codes);
      random_traffic(200);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sbslc_pkg.sv
hw/rtl/sbslc_front.sv
hw/rtl/sbslc_queue.sv
hw/rtl/sbslc_back.sv
hw/rtl/spi_byte_stuffed_link_codec.sv
tb/link_codec_check_pkg.sv
tb/spi_byte_stuffed_link_codec_tb.sv
